// File: sv/pcms_pkg.sv
// shared types, codes and helpers for the pulse channel modulation sequencer
// no dependencies; imported by every module of the block

package pcms_pkg;

	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 4;
	localparam int unsigned FREQ_W     = 11;
	localparam int unsigned LEN_W      = 7;
	localparam int unsigned VOL_W      = 4;
	localparam int unsigned IN_TDATA_W  = 24;
	localparam int unsigned OUT_TDATA_W = 24;

	localparam logic [LEN_W-1:0] LEN_FULL = 7'd64;
	localparam logic [VOL_W-1:0] VOL_MAX  = 4'd15;

	// register indexes of the configuration port
	localparam logic [CFG_IDX_W-1:0] REG_SWEEP_PERIOD = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SWEEP_NEGATE = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SWEEP_SHIFT  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_ENV_VOLUME   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_ENV_INCREASE = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_ENV_PERIOD   = 3'd5;

	typedef enum logic [1:0] {
		OP_TICK = 2'd0,
		OP_CTRL = 2'd1,
		OP_LEN  = 2'd2
	} op_t;

	typedef struct packed {
		logic [1:0]        op;
		logic              trigger;
		logic              length_enable;
		logic [FREQ_W-1:0] frequency_in;
		logic [5:0]        length_data;
	} item_t;

	typedef struct packed {
		logic [LEN_W-1:0]  length_left;
		logic              channel_active;
		logic [VOL_W-1:0]  volume;
		logic [FREQ_W-1:0] frequency_out;
	} result_t;

	// one sweep step: f plus or minus f shifted right; bit 11 flags overflow
	function automatic logic [FREQ_W:0] sweep_calc(
		input logic [FREQ_W-1:0] f,
		input logic [2:0]        shift,
		input logic              negate
	);
		logic [FREQ_W:0] d;
		d = {1'b0, f >> shift};
		return negate ? ({1'b0, f} - d) : ({1'b0, f} + d);
	endfunction

endpackage

// File: sv/pcms_core.sv
// channel state, configuration registers and the per-item update logic
// depends on pcms_pkg

module pcms_core import pcms_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  item_valid,
	input  item_t                 item,
	output result_t               result
);

	// configuration
	logic [2:0]       sweep_period_q, sweep_shift_q, env_period_q;
	logic             sweep_negate_q, env_increase_q;
	logic [VOL_W-1:0] env_volume_q;

	// channel state
	logic [2:0]        step_q, step_n;
	logic [LEN_W-1:0]  len_cnt_q, len_cnt_n;
	logic              len_on_q, len_on_n;
	logic              en_q, en_n;
	logic              sweep_on_q, sweep_on_n;
	logic [3:0]        sweep_cnt_q, sweep_cnt_n;
	logic [FREQ_W-1:0] shadow_q, shadow_n;
	logic [FREQ_W-1:0] freq_q, freq_n;
	logic [2:0]        env_cnt_q, env_cnt_n;
	logic [VOL_W-1:0]  vol_q, vol_n;

	logic [3:0]      sweep_reload;
	logic [FREQ_W:0] nf, nf2, trig_chk;
	logic            quirk;

	assign sweep_reload = (sweep_period_q == 3'd0) ? 4'd8 : {1'b0, sweep_period_q};
	assign quirk = !step_q[0];

	always_comb begin
		step_n      = step_q;
		len_cnt_n   = len_cnt_q;
		len_on_n    = len_on_q;
		en_n        = en_q;
		sweep_on_n  = sweep_on_q;
		sweep_cnt_n = sweep_cnt_q;
		shadow_n    = shadow_q;
		freq_n      = freq_q;
		env_cnt_n   = env_cnt_q;
		vol_n       = vol_q;
		nf          = sweep_calc(shadow_q, sweep_shift_q, sweep_negate_q);
		nf2         = sweep_calc(nf[FREQ_W-1:0], sweep_shift_q, sweep_negate_q);
		trig_chk    = sweep_calc(item.frequency_in, sweep_shift_q, sweep_negate_q);
		case (item.op)
			OP_TICK: begin
				step_n = step_q + 3'd1;
				// length on even steps
				if (!step_n[0] && len_on_q && len_cnt_q != '0) begin
					len_cnt_n = len_cnt_q - 7'd1;
					if (len_cnt_n == '0)
						en_n = 1'b0;
				end
				// sweep on steps 2 and 6
				if (step_n == 3'd2 || step_n == 3'd6) begin
					if (sweep_cnt_q != 4'd0)
						sweep_cnt_n = sweep_cnt_q - 4'd1;
					if (sweep_cnt_n == 4'd0) begin
						sweep_cnt_n = sweep_reload;
						if (sweep_on_q && sweep_period_q != 3'd0) begin
							if (nf[FREQ_W]) begin
								en_n = 1'b0;
							end else if (sweep_shift_q != 3'd0) begin
								shadow_n = nf[FREQ_W-1:0];
								freq_n   = nf[FREQ_W-1:0];
								if (nf2[FREQ_W])
									en_n = 1'b0;
							end
						end
					end
				end
				// envelope on step 7
				if (step_n == 3'd7 && env_period_q != 3'd0) begin
					if (env_cnt_q != 3'd0)
						env_cnt_n = env_cnt_q - 3'd1;
					if (env_cnt_n == 3'd0) begin
						env_cnt_n = env_period_q;
						if (env_increase_q) begin
							if (vol_q < VOL_MAX)
								vol_n = vol_q + 4'd1;
						end else if (vol_q != 4'd0) begin
							vol_n = vol_q - 4'd1;
						end
					end
				end
			end
			OP_CTRL: begin
				// extra length clock when enabling on a step that will not clock length
				if (quirk && !len_on_q && item.length_enable && len_cnt_q != '0) begin
					len_cnt_n = len_cnt_q - 7'd1;
					if (len_cnt_n == '0 && !item.trigger)
						en_n = 1'b0;
				end
				len_on_n = item.length_enable;
				freq_n   = item.frequency_in;
				if (item.trigger) begin
					en_n = 1'b1;
					if (len_cnt_n == '0)
						len_cnt_n = (item.length_enable && quirk) ? LEN_FULL - 7'd1 : LEN_FULL;
					vol_n       = env_volume_q;
					env_cnt_n   = env_period_q;
					shadow_n    = item.frequency_in;
					sweep_cnt_n = sweep_reload;
					sweep_on_n  = (sweep_period_q != 3'd0) || (sweep_shift_q != 3'd0);
					if (sweep_shift_q != 3'd0 && trig_chk[FREQ_W])
						en_n = 1'b0;
				end
			end
			OP_LEN: begin
				len_cnt_n = LEN_FULL - {1'b0, item.length_data};
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		result.frequency_out  = freq_n;
		result.volume         = vol_n;
		result.length_left    = len_cnt_n;
		result.channel_active = en_n && env_volume_q != 4'd0 && !(len_on_n && len_cnt_n == '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sweep_period_q <= 3'd0;
			sweep_negate_q <= 1'b0;
			sweep_shift_q  <= 3'd0;
			env_volume_q   <= 4'd0;
			env_increase_q <= 1'b0;
			env_period_q   <= 3'd0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SWEEP_PERIOD: sweep_period_q <= cfg_data[2:0];
				REG_SWEEP_NEGATE: sweep_negate_q <= cfg_data[0];
				REG_SWEEP_SHIFT:  sweep_shift_q  <= cfg_data[2:0];
				REG_ENV_VOLUME:   env_volume_q   <= cfg_data;
				REG_ENV_INCREASE: env_increase_q <= cfg_data[0];
				REG_ENV_PERIOD:   env_period_q   <= cfg_data[2:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q      <= 3'd7;
			len_cnt_q   <= '0;
			len_on_q    <= 1'b0;
			en_q        <= 1'b0;
			sweep_on_q  <= 1'b0;
			sweep_cnt_q <= 4'd0;
			shadow_q    <= '0;
			freq_q      <= '0;
			env_cnt_q   <= 3'd0;
			vol_q       <= 4'd0;
		end else if (item_valid) begin
			step_q      <= step_n;
			len_cnt_q   <= len_cnt_n;
			len_on_q    <= len_on_n;
			en_q        <= en_n;
			sweep_on_q  <= sweep_on_n;
			sweep_cnt_q <= sweep_cnt_n;
			shadow_q    <= shadow_n;
			freq_q      <= freq_n;
			env_cnt_q   <= env_cnt_n;
			vol_q       <= vol_n;
		end else if (cfg_we && cfg_index == REG_ENV_VOLUME && cfg_data == 4'd0) begin
			// converter off kills the channel
			en_q <= 1'b0;
		end
	end

	a_len_range: assert property (@(posedge clk) disable iff (!arst_n)
		len_cnt_q <= LEN_FULL)
		else $error("length count above full");

	a_sweep_range: assert property (@(posedge clk) disable iff (!arst_n)
		sweep_cnt_q <= 4'd8)
		else $error("sweep timer above eight");

	a_len_load: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item.op == OP_LEN |=>
		len_cnt_q == LEN_FULL - {1'b0, $past(item.length_data)})
		else $error("length write did not load the counter");

	a_trig_enable: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item.op == OP_CTRL && item.trigger && sweep_shift_q == 3'd0 |=> en_q)
		else $error("trigger without sweep check left channel disabled");

endmodule

// File: sv/pcms_out_reg.sv
// result register on the master side; holds a result until the transfer completes
// depends on pcms_pkg

module pcms_out_reg import pcms_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   load,
	input  result_t                result,
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [OUT_TDATA_W-1:0] m_tdata
);

	logic    valid_s2;
	result_t res_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (load) begin
			valid_s2 <= 1'b1;
		end else if (m_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load)
			res_s2 <= result;
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {{(OUT_TDATA_W - $bits(result_t)){1'b0}}, res_s2};

endmodule

// File: sv/pulse_channel_modulation_sequencer_top.sv
// top level of the pulse channel modulation sequencer: input stage and handshake
// depends on pcms_pkg, pcms_core, pcms_out_reg
//
// Control core of a sweep-capable square sound channel. Each transfer on the
// slave stream is one event: s_tuser carries the kind (0 sequencer tick,
// 1 control write, 2 length write) and s_tdata the event fields. Every event
// gives exactly one result on the master stream: frequency, volume, active
// flag and remaining length.
// Channel settings (sweep and envelope) go through the cfg_we / cfg_index /
// cfg_data write port and take effect at the next event; write them only
// while no event is in flight.
// From the input transfer, an event goes into the input register, then the
// state update writes its result into the result register, which drives
// m_tvalid. An event can be accepted every cycle while the receiver does not
// stall; the channel state update between the input register and the result
// register is combinational.
// When the receiver stalls, the result stays in the result register and one
// more event waits in the input register; s_tready drops only when both are
// full. Reset clears both stages, all settings to zero and the step counter
// to seven, so the first tick lands on step zero.

module pulse_channel_modulation_sequencer_top import pcms_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	// trigger, length_enable, frequency_in[10:0], length_data[5:0], zero pad
	input  logic [IN_TDATA_W-1:0]  s_tdata,
	// op[1:0]
	input  logic [1:0]             s_tuser,
	output logic                   m_tvalid,
	input  logic                   m_tready,
	// frequency_out[10:0], volume[3:0], channel_active, length_left[6:0], zero pad
	output logic [OUT_TDATA_W-1:0] m_tdata
);

	logic    valid_s1;
	item_t   item_s1;
	logic    advance;
	result_t result;

	assign advance  = valid_s1 && (!m_tvalid || m_tready);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			item_s1.op            <= s_tuser;
			item_s1.trigger       <= s_tdata[0];
			item_s1.length_enable <= s_tdata[1];
			item_s1.frequency_in  <= s_tdata[12:2];
			item_s1.length_data   <= s_tdata[18:13];
		end
	end

	pcms_core u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.item_valid (advance),
		.item       (item_s1),
		.result     (result)
	);

	pcms_out_reg u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (advance),
		.result   (result),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1 && $stable(item_s1))
		else $error("input stage lost a waiting event");

	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |-> !advance)
		else $error("result register overwritten while stalled");

	a_ready_free: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> s_tready)
		else $error("empty input stage refused a transfer");

endmodule

// File: tb/tb_pulse_channel_modulation_sequencer_top.sv
// self-checking testbench for the pulse channel modulation sequencer top level
// depends on pcms_pkg and pulse_channel_modulation_sequencer_top; predicts every
// result from its own channel model and checks each master-side transfer in order
`timescale 1ns / 1ps

module tb_pulse_channel_modulation_sequencer_top;
	import pcms_pkg::*;

	localparam int unsigned CYCLE_LIMIT  = 500000;
	localparam int unsigned HOLD_CYCLES  = 80;
	localparam int unsigned MAX_REPORTS  = 10;
	localparam int unsigned EXP_DEPTH    = 64;
	localparam logic [11:0] FREQ_LIMIT   = 12'd2047;
	localparam logic [1:0]  OP_UNUSED    = 2'd3;
	localparam logic [3:0]  SWEEP_RELOAD = 4'd8;

	logic                   clk       = 1'b0;
	logic                   arst_n    = 1'b0;
	logic                   cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0]   cfg_index = '0;
	logic [CFG_DATA_W-1:0]  cfg_data  = '0;
	logic                   s_tvalid  = 1'b0;
	logic                   s_tready;
	// trigger, length_enable, frequency_in[10:0], length_data[5:0], zero pad
	logic [IN_TDATA_W-1:0]  s_tdata   = '0;
	// op[1:0]
	logic [1:0]             s_tuser   = '0;
	logic                   m_tvalid;
	logic                   m_tready  = 1'b0;
	// frequency_out[10:0], volume[3:0], channel_active, length_left[6:0], zero pad
	logic [OUT_TDATA_W-1:0] m_tdata;

	pulse_channel_modulation_sequencer_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	always #4 clk = ~clk;

	// channel settings as last written
	logic [2:0] cfg_sweep_period, cfg_sweep_shift, cfg_env_period;
	logic       cfg_sweep_negate, cfg_env_increase;
	logic [3:0] cfg_env_volume;

	// channel state
	logic [2:0]  seq_pos;
	logic [6:0]  len_count;
	logic        len_on, chan_on, sweep_armed;
	logic [3:0]  sweep_timer;
	logic [10:0] sweep_shadow, freq_now;
	logic [2:0]  env_timer;
	logic [3:0]  vol_now;

	// expected results in transfer order
	result_t     exp_fifo [EXP_DEPTH];
	logic [5:0]  exp_wr         = '0;
	logic [5:0]  exp_rd         = '0;
	int unsigned exp_count      = 0;
	int unsigned mismatch_count = 0;
	int unsigned cycle_count    = 0;
	bit          send_idle      = 1'b1;
	bit          recv_idle      = 1'b1;
	bit          hold_req       = 1'b0;
	result_t     got_result, want_result;

	task automatic reset_channel_model();
		cfg_sweep_period = '0; cfg_sweep_negate = 1'b0; cfg_sweep_shift = '0;
		cfg_env_volume = '0; cfg_env_increase = 1'b0; cfg_env_period = '0;
		seq_pos = 3'd7; len_count = '0; len_on = 1'b0; chan_on = 1'b0;
		sweep_armed = 1'b0; sweep_timer = '0; sweep_shadow = '0; freq_now = '0;
		env_timer = '0; vol_now = '0;
	endtask

	function automatic logic [11:0] next_sweep_freq(input logic [10:0] f);
		logic [11:0] d;
		d = {1'b0, f} >> cfg_sweep_shift;
		return cfg_sweep_negate ? ({1'b0, f} - d) : ({1'b0, f} + d);
	endfunction

	task automatic advance_channel(input logic [1:0] op, input logic trig, input logic len_en,
			input logic [10:0] freq_in, input logic [5:0] len_data, output result_t res);
		logic        even_pos;
		logic [11:0] nf;
		case (op)
			OP_TICK: begin
				seq_pos = seq_pos + 3'd1;
				if (!seq_pos[0] && len_on && len_count != 0) begin
					len_count = len_count - 7'd1;
					if (len_count == 0)
						chan_on = 1'b0;
				end
				if (seq_pos == 3'd2 || seq_pos == 3'd6) begin
					if (sweep_timer != 0)
						sweep_timer = sweep_timer - 4'd1;
					if (sweep_timer == 0) begin
						sweep_timer = (cfg_sweep_period != 0) ? {1'b0, cfg_sweep_period}
								: SWEEP_RELOAD;
						if (sweep_armed && cfg_sweep_period != 0) begin
							nf = next_sweep_freq(sweep_shadow);
							if (nf > FREQ_LIMIT) begin
								chan_on = 1'b0;
							end else if (cfg_sweep_shift != 0) begin
								sweep_shadow = nf[10:0];
								freq_now     = nf[10:0];
								if (next_sweep_freq(nf[10:0]) > FREQ_LIMIT)
									chan_on = 1'b0;
							end
						end
					end
				end
				if (seq_pos == 3'd7 && cfg_env_period != 0) begin
					if (env_timer != 0)
						env_timer = env_timer - 3'd1;
					if (env_timer == 0) begin
						env_timer = cfg_env_period;
						if (cfg_env_increase) begin
							if (vol_now < VOL_MAX)
								vol_now = vol_now + 4'd1;
						end else if (vol_now != 0) begin
							vol_now = vol_now - 4'd1;
						end
					end
				end
			end
			OP_CTRL: begin
				// next step will not clock length, so enabling it clocks once now
				even_pos = !seq_pos[0];
				if (even_pos && !len_on && len_en && len_count != 0) begin
					len_count = len_count - 7'd1;
					if (len_count == 0 && !trig)
						chan_on = 1'b0;
				end
				len_on   = len_en;
				freq_now = freq_in;
				if (trig) begin
					chan_on = 1'b1;
					if (len_count == 0)
						len_count = (len_en && even_pos) ? LEN_FULL - 7'd1 : LEN_FULL;
					vol_now      = cfg_env_volume;
					env_timer    = cfg_env_period;
					sweep_shadow = freq_now;
					sweep_timer  = (cfg_sweep_period != 0) ? {1'b0, cfg_sweep_period}
							: SWEEP_RELOAD;
					sweep_armed  = (cfg_sweep_period != 0 || cfg_sweep_shift != 0);
					if (cfg_sweep_shift != 0 && next_sweep_freq(sweep_shadow) > FREQ_LIMIT)
						chan_on = 1'b0;
				end
			end
			OP_LEN: len_count = LEN_FULL - {1'b0, len_data};
			default: ;
		endcase
		res.frequency_out  = freq_now;
		res.volume         = vol_now;
		res.channel_active = chan_on && cfg_env_volume != 0 && !(len_on && len_count == 0);
		res.length_left    = len_count;
	endtask

	// mostly no gap, some short ones and a few long stretches
	function automatic int unsigned pick_gap(input bit enabled);
		int unsigned r;
		if (!enabled)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// offer one event and wait for its transfer; valid stays high afterwards
	task automatic send_event(input logic [1:0] op, input logic trig, input logic len_en,
			input logic [10:0] freq_in, input logic [5:0] len_data);
		int unsigned gap;
		bit          took;
		result_t     res;
		gap = pick_gap(send_idle);
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= {5'b0, len_data, freq_in, len_en, trig};
		do begin
			@(negedge clk);
			took = s_tready;
			@(posedge clk);
		end while (!took);
		advance_channel(op, trig, len_en, freq_in, len_data, res);
		exp_fifo[exp_wr] = res;
		exp_wr = exp_wr + 6'd1;
		exp_count++;
	endtask

	task automatic send_ticks(input int unsigned n);
		repeat (n)
			send_event(OP_TICK, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
					11'($urandom_range(0, 2047)), 6'($urandom_range(0, 63)));
	endtask

	task automatic drain_results();
		s_tvalid <= 1'b0;
		while (exp_count != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [3:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		case (idx)
			REG_SWEEP_PERIOD: cfg_sweep_period = val[2:0];
			REG_SWEEP_NEGATE: cfg_sweep_negate = val[0];
			REG_SWEEP_SHIFT:  cfg_sweep_shift  = val[2:0];
			REG_ENV_VOLUME: begin
				cfg_env_volume = val;
				if (val == 0)
					chan_on = 1'b0;
			end
			REG_ENV_INCREASE: cfg_env_increase = val[0];
			REG_ENV_PERIOD:   cfg_env_period   = val[2:0];
			default: ;
		endcase
	endtask

	task automatic apply_settings(input logic [2:0] sp, input logic neg, input logic [2:0] sh,
			input logic [3:0] vol, input logic inc, input logic [2:0] ep);
		drain_results();
		@(posedge clk);
		write_reg(REG_SWEEP_PERIOD, {1'b0, sp});
		write_reg(REG_SWEEP_NEGATE, {3'b0, neg});
		write_reg(REG_SWEEP_SHIFT,  {1'b0, sh});
		write_reg(REG_ENV_VOLUME,   vol);
		write_reg(REG_ENV_INCREASE, {3'b0, inc});
		write_reg(REG_ENV_PERIOD,   {1'b0, ep});
		cfg_we <= 1'b0;
	endtask

	task automatic send_random_event();
		int unsigned r;
		logic [10:0] f;
		logic [5:0]  n;
		logic        b0, b1;
		r = $urandom_range(0, 99);
		// lean toward short lengths and high frequencies so expiry and overflow happen
		f = ($urandom_range(0, 1) != 0) ? 11'($urandom_range(1400, 2047))
				: 11'($urandom_range(0, 2047));
		n = ($urandom_range(0, 1) != 0) ? 6'($urandom_range(44, 63)) : 6'($urandom_range(0, 63));
		b0 = 1'($urandom_range(0, 1));
		b1 = 1'($urandom_range(0, 1));
		if (r < 62)
			send_event(OP_TICK, b0, b1, f, n);
		else if (r < 74)
			send_event(OP_CTRL, 1'b1, b1, f, n);
		else if (r < 84)
			send_event(OP_CTRL, 1'b0, b1, f, n);
		else if (r < 95)
			send_event(OP_LEN, b0, b1, f, n);
		else
			send_event(OP_UNUSED, b0, b1, f, n);
	endtask

	task automatic test_reset_defaults();
		send_event(OP_TICK, 1'b1, 1'b1, 11'd2047, 6'd63);
		send_event(OP_UNUSED, 1'b1, 1'b1, 11'd2047, 6'd63);
		drain_results();
	endtask

	task automatic test_directed();
		apply_settings(3'd1, 1'b0, 3'd1, 4'd15, 1'b0, 3'd1);
		send_event(OP_LEN, 1'b0, 1'b0, 11'd0, 6'd0);
		send_event(OP_LEN, 1'b1, 1'b1, 11'd2047, 6'd63);
		// even step, enabling length eats the last count
		send_event(OP_CTRL, 1'b0, 1'b1, 11'd100, 6'd0);
		// zero length under the quirk reloads 63; frequency overflows at once
		send_event(OP_CTRL, 1'b1, 1'b1, 11'd2047, 6'd0);
		send_event(OP_CTRL, 1'b1, 1'b0, 11'd0, 6'd63);
		send_event(OP_CTRL, 1'b0, 1'b0, 11'd1000, 6'd0);
		send_ticks(4);
		// sweep stores 1800 and the follow-up check overflows
		send_event(OP_CTRL, 1'b1, 1'b1, 11'd1200, 6'd0);
		send_ticks(4);
		send_event(OP_UNUSED, 1'b1, 1'b1, 11'd2047, 6'd63);
		apply_settings(3'd0, 1'b1, 3'd7, 4'd1, 1'b1, 3'd7);
		send_event(OP_CTRL, 1'b1, 1'b1, 11'd2047, 6'd0);
		send_ticks(8);
		// converter off
		apply_settings(3'd7, 1'b0, 3'd0, 4'd0, 1'b0, 3'd0);
		send_event(OP_CTRL, 1'b1, 1'b0, 11'd2047, 6'd0);
		send_ticks(2);
		drain_results();
	endtask

	task automatic test_backpressure();
		apply_settings(3'd2, 1'b0, 3'd3, 4'd9, 1'b1, 3'd2);
		send_idle = 1'b0;
		recv_idle = 1'b0;
		hold_req  = 1'b1;
		repeat (24)
			send_random_event();
		drain_results();
		send_idle = 1'b1;
		recv_idle = 1'b1;
	endtask

	task automatic test_random();
		for (int ph = 0; ph < 7; ph++) begin
			if (ph == 0)
				apply_settings(3'd7, 1'b1, 3'd7, 4'd15, 1'b1, 3'd7);
			else if (ph == 6)
				apply_settings(3'd0, 1'b0, 3'd0, 4'd0, 1'b0, 3'd0);
			else
				apply_settings(3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)),
						3'($urandom_range(0, 7)), 4'($urandom_range(1, 15)),
						1'($urandom_range(0, 1)), 3'($urandom_range(0, 7)));
			send_idle = (ph != 3);
			recv_idle = (ph != 3);
			repeat (200)
				send_random_event();
		end
		drain_results();
		send_idle = 1'b1;
		recv_idle = 1'b1;
	endtask

	// result receiver: random stalls plus one long hold-off on request
	initial begin
		int unsigned g;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else begin
				g = pick_gap(recv_idle);
				if (g == 0) begin
					m_tready <= 1'b1;
				end else begin
					m_tready <= 1'b0;
					repeat (g - 1) @(posedge clk);
				end
			end
		end
	end

	// inputs only change at the rising edge, so the transfer is known at the falling one
	always @(negedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			got_result = result_t'(m_tdata[22:0]);
			if (exp_count == 0) begin
				mismatch_count++;
				if (mismatch_count <= MAX_REPORTS)
					$display("unexpected result transfer: freq %0d vol %0d act %0d len %0d",
							got_result.frequency_out, got_result.volume,
							got_result.channel_active, got_result.length_left);
			end else begin
				want_result = exp_fifo[exp_rd];
				exp_rd = exp_rd + 6'd1;
				exp_count--;
				if (got_result.frequency_out !== want_result.frequency_out ||
						got_result.volume !== want_result.volume ||
						got_result.channel_active !== want_result.channel_active ||
						got_result.length_left !== want_result.length_left) begin
					mismatch_count++;
					if (mismatch_count <= MAX_REPORTS)
						$display("mismatch: exp freq %0d vol %0d act %0d len %0d,",
								want_result.frequency_out, want_result.volume,
								want_result.channel_active, want_result.length_left,
								" got freq %0d vol %0d act %0d len %0d",
								got_result.frequency_out, got_result.volume,
								got_result.channel_active, got_result.length_left);
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	initial begin
		reset_channel_model();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_defaults();
		test_directed();
		test_backpressure();
		test_random();
		drain_results();
		repeat (10) @(posedge clk);
		if (mismatch_count == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

// File: sim.f
sv/pcms_pkg.sv
sv/pcms_core.sv
sv/pcms_out_reg.sv
sv/pulse_channel_modulation_sequencer_top.sv
tb/tb_pulse_channel_modulation_sequencer_top.sv
